/* sv/jp1d_pkg.sv */
// shared types and constants of the 1-d jacobi poisson solver
package jp1d_pkg;

  localparam int FIELD_W     = 32;
  localparam int PIDX_W      = 5;
  localparam int STEP_W      = 32;
  localparam int RESID_W     = 63;
  localparam int ITER_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 63;
  localparam int PROD_W      = 64;
  localparam int RND_SHIFT   = 16;
  localparam int QW          = PROD_W - RND_SHIFT;
  localparam int NORM_W      = 64;

  localparam logic [STEP_W-1:0]         RST_STEP_SQUARED    = 32'd655;
  localparam logic [RESID_W-1:0]        RST_RESIDUAL_LIMIT  = 63'd42950;
  localparam logic [ITER_W-1:0]         RST_ITERATION_LIMIT = 16'd25000;
  localparam logic signed [FIELD_W-1:0] RST_LEFT_BOUNDARY   = 32'sd655360;
  localparam logic signed [FIELD_W-1:0] RST_RIGHT_BOUNDARY  = 32'sd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_SQUARED    = 3'd0,
    REG_RESIDUAL_LIMIT  = 3'd1,
    REG_ITERATION_LIMIT = 3'd2,
    REG_LEFT_BOUNDARY   = 3'd3,
    REG_RIGHT_BOUNDARY  = 3'd4
  } jp1d_cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SWEEP,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_HOLD
  } jp1d_state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } jp1d_pt_ctl_t;

endpackage

/* sv/jp1d_point_pipe.sv */
// pipelined point update: new value, saturation, squared change
module jp1d_point_pipe #(
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX_WIDTH = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  jp1d_pkg::jp1d_pt_ctl_t                in_ctl,
  input  logic [INDEX_WIDTH-1:0]                in_idx,
  input  logic signed [((VALUE_WIDTH > jp1d_pkg::FIELD_W) ?
                        VALUE_WIDTH : jp1d_pkg::FIELD_W)-1:0] in_left,
  input  logic signed [((VALUE_WIDTH > jp1d_pkg::FIELD_W) ?
                        VALUE_WIDTH : jp1d_pkg::FIELD_W)-1:0] in_right,
  input  logic signed [VALUE_WIDTH-1:0]         in_old,
  input  logic signed [jp1d_pkg::PROD_W-1:0]    in_prod,
  output jp1d_pkg::jp1d_pt_ctl_t                wr_ctl,
  output logic [INDEX_WIDTH-1:0]                wr_idx,
  output logic signed [VALUE_WIDTH-1:0]         wr_data,
  output jp1d_pkg::jp1d_pt_ctl_t                sq_ctl,
  output logic [jp1d_pkg::NORM_W-1:0]           sq
);
  import jp1d_pkg::*;

  localparam int SW = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int DW = (((SW + 1) > QW) ? (SW + 1) : QW) + 1;
  localparam int AW = VALUE_WIDTH + 1;
  localparam int EW = (AW > (FIELD_W + 1)) ? AW : (FIELD_W + 1);
  localparam logic signed [DW-1:0] VMAX =
    {{(DW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN =
    {{(DW - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
  localparam logic [EW-1:0] SQ_LIMIT = {{(EW - FIELD_W){1'b0}}, {FIELD_W{1'b1}}};

  jp1d_pt_ctl_t a_ctl, b_ctl, c_ctl, d_ctl;
  logic [INDEX_WIDTH-1:0] a_idx, b_idx;
  logic signed [SW:0] a_sum;
  logic signed [QW-1:0] a_q;
  logic signed [VALUE_WIDTH-1:0] a_old, b_old, b_nv;
  logic [FIELD_W-1:0] c_mag;
  logic c_big;
  logic [NORM_W-1:0] d_sq;

  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [DW-1:0] b_t, b_h;
  logic signed [VALUE_WIDTH-1:0] b_sat;
  logic signed [AW-1:0] c_diff;
  logic [AW-1:0] c_abs;
  logic [NORM_W-1:0] d_prod;

  // round the charge term to q16
  assign prod_rnd = in_prod + PROD_W'(32768);

  assign b_t = DW'(a_sum) - DW'(a_q) + DW'(1);
  assign b_h = b_t >>> 1;
  always_comb begin
    if (b_h > VMAX) begin
      b_sat = VMAX[VALUE_WIDTH-1:0];
    end else if (b_h < VMIN) begin
      b_sat = VMIN[VALUE_WIDTH-1:0];
    end else begin
      b_sat = b_h[VALUE_WIDTH-1:0];
    end
  end

  assign c_diff = {b_nv[VALUE_WIDTH-1], b_nv} - {b_old[VALUE_WIDTH-1], b_old};
  assign c_abs  = c_diff[AW-1] ? AW'(-c_diff) : AW'(c_diff);
  assign d_prod = c_mag * c_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
      c_ctl <= '0;
      d_ctl <= '0;
    end else begin
      a_ctl <= in_ctl;
      b_ctl <= a_ctl;
      c_ctl <= b_ctl;
      d_ctl <= c_ctl;
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= in_idx;
    a_old <= in_old;
    a_sum <= {in_left[SW-1], in_left} + {in_right[SW-1], in_right};
    a_q   <= prod_rnd[PROD_W-1:RND_SHIFT];
    b_idx <= a_idx;
    b_old <= a_old;
    b_nv  <= b_sat;
    c_mag <= FIELD_W'(c_abs);
    c_big <= EW'(c_abs) > SQ_LIMIT;
    d_sq  <= c_big ? '1 : d_prod;
  end

  assign wr_ctl  = b_ctl;
  assign wr_idx  = b_idx;
  assign wr_data = b_nv;
  assign sq_ctl  = d_ctl;
  assign sq      = d_sq;

endmodule

/* sv/jacobi_poisson_1d_solver_top.sv */
// top level of the 1-d jacobi poisson solver: memories, sweep control, ports
//
// Load items write one grid point (charge and starting field) and are taken
// only while the block is idle. A solve item loads its point and then runs
// jacobi sweeps over the grid until the squared change norm drops below
// residual_limit or iteration_limit sweeps are done, then returns one result
// per grid point. A solve runs all its sweeps before the first result: each
// sweep streams the grid through the single read port of the field memory,
// one point per cycle, and then drains the update and norm pipeline before
// the stop decision. Results leave one at a time, each read from the field
// memory when its predecessor is taken. The field memory holds two banks that
// swap roles after every sweep; valid bits give zero for points that were
// never loaded. Configuration writes are taken in any cycle and must only
// happen while the block is idle.
module jacobi_poisson_1d_solver_top #(
  parameter int POINTS      = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jp1d_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [jp1d_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic [jp1d_pkg::PIDX_W-1:0]           point_index,
  input  logic signed [jp1d_pkg::FIELD_W-1:0]   charge_density,
  input  logic signed [jp1d_pkg::FIELD_W-1:0]   initial_field,
  input  logic                                  mode,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [jp1d_pkg::PIDX_W-1:0]           out_index,
  output logic signed [jp1d_pkg::FIELD_W-1:0]   field_value,
  output logic [jp1d_pkg::ITER_W-1:0]           sweeps_used,
  output logic                                  converged,
  output logic                                  last_point
);
  import jp1d_pkg::*;

  localparam int IW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS + 1);
  localparam int AW = IW + 1;
  localparam int LW = (IW > PIDX_W) ? IW : PIDX_W;
  localparam int SW = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam logic signed [SW-1:0] VMAX_S =
    {{(SW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN_S =
    {{(SW - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

  // configuration registers
  logic [STEP_W-1:0]         step_squared;
  logic [RESID_W-1:0]        residual_limit;
  logic [ITER_W-1:0]         iteration_limit;
  logic signed [FIELD_W-1:0] left_boundary;
  logic signed [FIELD_W-1:0] right_boundary;

  // control state
  jp1d_state_t     state, state_next;
  logic [CW-1:0]   sw_cnt, sw_cnt_next;
  logic [IW-1:0]   out_cnt, out_cnt_next;
  logic [ITER_W-1:0] sweeps, sweeps_next;
  logic            conv, conv_next;
  logic            cur, cur_next;
  logic            norm_clr;
  logic            fill_valid;
  logic [NORM_W-1:0] norm;
  logic            sweep_done;
  logic [POINTS-1:0] fvalid, cvalid;

  // memories and read side
  logic signed [VALUE_WIDTH-1:0] fmem [0:(2**AW)-1];
  logic signed [FIELD_W-1:0]     cmem [0:(2**IW)-1];
  logic signed [VALUE_WIDTH-1:0] f_rdata;
  logic signed [FIELD_W-1:0]     c_rdata;
  logic                          rd_fvalid, rd_cvalid;
  logic [IW-1:0]                 rd_idx;
  logic                          f_we;
  logic [AW-1:0]                 f_waddr;
  logic signed [VALUE_WIDTH-1:0] f_wdata;

  // load path
  logic                          item_fire;
  logic [LW-1:0]                 idx_ext;
  logic                          in_range;
  logic [IW-1:0]                 load_idx;
  logic                          load_we;
  logic signed [SW-1:0]          init_ext;
  logic signed [VALUE_WIDTH-1:0] init_sat;

  // sweep window
  logic                          s1_valid;
  logic [CW-1:0]                 s1_j, s1_jm1;
  logic                          s1_tail;
  logic signed [VALUE_WIDTH-1:0] fval;
  logic signed [FIELD_W-1:0]     cval;
  logic signed [VALUE_WIDTH-1:0] w_prev, w_cur;
  logic signed [PROD_W-1:0]      p_cur;
  logic signed [PROD_W:0]        prod_full;

  jp1d_pt_ctl_t                  pt_ctl;
  logic [IW-1:0]                 pt_idx;
  logic signed [SW-1:0]          pt_left, pt_right;
  jp1d_pt_ctl_t                  wr_ctl;
  logic [IW-1:0]                 wr_idx;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  jp1d_pt_ctl_t                  sq_ctl;
  logic [NORM_W-1:0]             sq;
  logic [NORM_W:0]               norm_sum;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_squared    <= RST_STEP_SQUARED;
      residual_limit  <= RST_RESIDUAL_LIMIT;
      iteration_limit <= RST_ITERATION_LIMIT;
      left_boundary   <= RST_LEFT_BOUNDARY;
      right_boundary  <= RST_RIGHT_BOUNDARY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_SQUARED:    step_squared    <= cfg_data[STEP_W-1:0];
        REG_RESIDUAL_LIMIT:  residual_limit  <= cfg_data[RESID_W-1:0];
        REG_ITERATION_LIMIT: iteration_limit <= cfg_data[ITER_W-1:0];
        REG_LEFT_BOUNDARY:   left_boundary   <= $signed(cfg_data[FIELD_W-1:0]);
        REG_RIGHT_BOUNDARY:  right_boundary  <= $signed(cfg_data[FIELD_W-1:0]);
        default: ;
      endcase
    end
  end

  // load requests
  assign item_fire = item_valid && item_ready;
  assign idx_ext   = LW'(point_index);
  assign in_range  = {1'b0, idx_ext} < (LW + 1)'(POINTS);
  assign load_idx  = idx_ext[IW-1:0];
  assign load_we   = item_fire && in_range;
  assign init_ext  = SW'(initial_field);

  always_comb begin
    if (init_ext > VMAX_S) begin
      init_sat = VMAX_S[VALUE_WIDTH-1:0];
    end else if (init_ext < VMIN_S) begin
      init_sat = VMIN_S[VALUE_WIDTH-1:0];
    end else begin
      init_sat = init_ext[VALUE_WIDTH-1:0];
    end
  end

  // memory ports
  assign rd_idx  = (state == ST_SWEEP) ? sw_cnt[IW-1:0] : out_cnt;
  assign f_we    = load_we || wr_ctl.valid;
  assign f_waddr = load_we ? {cur, load_idx} : {~cur, wr_idx};
  assign f_wdata = load_we ? init_sat : wr_data;

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (load_we) begin
      cmem[load_idx] <= charge_density;
    end
    f_rdata   <= fmem[{cur, rd_idx}];
    c_rdata   <= cmem[rd_idx];
    rd_fvalid <= fvalid[rd_idx];
    rd_cvalid <= cvalid[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
      cvalid <= '0;
    end else begin
      if (fill_valid) begin
        fvalid <= '1;
      end else if (load_we) begin
        fvalid[load_idx] <= 1'b1;
      end
      if (load_we) begin
        cvalid[load_idx] <= 1'b1;
      end
    end
  end

  // sliding window over the old grid
  assign fval      = rd_fvalid ? f_rdata : '0;
  assign cval      = rd_cvalid ? c_rdata : '0;
  assign prod_full = $signed({1'b0, step_squared}) * cval;
  assign s1_tail   = (s1_j == CW'(POINTS));
  assign s1_jm1    = s1_j - CW'(1);

  assign pt_ctl.valid = s1_valid && (s1_j != '0);
  assign pt_ctl.last  = s1_tail;
  assign pt_idx       = s1_jm1[IW-1:0];
  assign pt_left      = (s1_j == CW'(1)) ? SW'(left_boundary) : SW'(w_prev);
  assign pt_right     = s1_tail ? SW'(right_boundary) : SW'(fval);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    s1_j <= sw_cnt;
    if (s1_valid) begin
      w_prev <= w_cur;
      w_cur  <= fval;
      p_cur  <= prod_full[PROD_W-1:0];
    end
  end

  jp1d_point_pipe #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .INDEX_WIDTH (IW)
  ) u_point_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (pt_ctl),
    .in_idx   (pt_idx),
    .in_left  (pt_left),
    .in_right (pt_right),
    .in_old   (w_cur),
    .in_prod  (p_cur),
    .wr_ctl   (wr_ctl),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .sq_ctl   (sq_ctl),
    .sq       (sq)
  );

  // squared change norm, saturating
  assign norm_sum = {1'b0, norm} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      norm       <= '0;
      sweep_done <= 1'b0;
    end else begin
      sweep_done <= sq_ctl.valid && sq_ctl.last;
      if (norm_clr) begin
        norm <= '0;
      end else if (sq_ctl.valid) begin
        norm <= norm_sum[NORM_W] ? '1 : norm_sum[NORM_W-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sw_cnt  <= '0;
      out_cnt <= '0;
      sweeps  <= '0;
      conv    <= 1'b0;
      cur     <= 1'b0;
    end else begin
      state   <= state_next;
      sw_cnt  <= sw_cnt_next;
      out_cnt <= out_cnt_next;
      sweeps  <= sweeps_next;
      conv    <= conv_next;
      cur     <= cur_next;
    end
  end

  always_comb begin
    state_next   = state;
    sw_cnt_next  = sw_cnt;
    out_cnt_next = out_cnt;
    sweeps_next  = sweeps;
    conv_next    = conv;
    cur_next     = cur;
    norm_clr     = 1'b0;
    fill_valid   = 1'b0;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_fire && mode) begin
          state_next  = ST_START;
          sweeps_next = '0;
          conv_next   = 1'b0;
        end
      end
      ST_START: begin
        if (iteration_limit == '0) begin
          state_next   = ST_OUT_RD;
          out_cnt_next = '0;
        end else begin
          state_next  = ST_SWEEP;
          sw_cnt_next = '0;
          norm_clr    = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (sw_cnt == CW'(POINTS)) begin
          state_next = ST_DRAIN;
        end else begin
          sw_cnt_next = sw_cnt + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (sweep_done) begin
          sweeps_next = sweeps + ITER_W'(1);
          cur_next    = ~cur;
          fill_valid  = 1'b1;
          conv_next   = norm < {1'b0, residual_limit};
          if (conv_next || (sweeps_next == iteration_limit)) begin
            state_next   = ST_OUT_RD;
            out_cnt_next = '0;
          end else begin
            state_next  = ST_SWEEP;
            sw_cnt_next = '0;
            norm_clr    = 1'b1;
          end
        end
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        result_valid = 1'b1;
        if (result_ready) begin
          if (out_cnt == IW'(POINTS - 1)) begin
            state_next = ST_IDLE;
          end else begin
            out_cnt_next = out_cnt + IW'(1);
            state_next   = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result payload
  assign out_index   = PIDX_W'(out_cnt);
  assign field_value = FIELD_W'(fval);
  assign sweeps_used = sweeps;
  assign converged   = conv;
  assign last_point  = (out_cnt == IW'(POINTS - 1));

`ifndef SYNTH
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(load_we && wr_ctl.valid))
    else $error("load and sweep write the field memory in the same cycle");

  a_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    wr_ctl.valid |-> ({1'b0, wr_idx} < (IW + 1)'(POINTS)))
    else $error("sweep write beyond the grid");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    sweep_done |-> (state == ST_DRAIN))
    else $error("sweep finished outside the drain phase");

  a_quiet_output: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!s1_valid && !pt_ctl.valid && !sq_ctl.valid))
    else $error("sweep traffic while results are sent");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last_point) |=> item_ready)
    else $error("no return to idle after the last result");
`endif

endmodule
